// ===== rtl/core/sound_chip_timers_and_interrupt_ctrl_top_macros.svh =====
// Assertion macros shared by the timer and interrupt controller RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef SOUND_CHIP_TIMERS_AND_INTERRUPT_CTRL_TOP_MACROS_SVH
`define SOUND_CHIP_TIMERS_AND_INTERRUPT_CTRL_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define SCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define SCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sctic_pkg.sv =====
// Types, register offsets and the interrupt check function for the
// sound-chip timer and interrupt controller. No dependencies.
package sctic_pkg;

  localparam int LEVEL_ENTRIES = 8;
  localparam int IRQ_BITS      = 11;
  localparam int IRQ_TIMER_A   = 6;
  localparam int IRQ_TIMER_B   = 7;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [15:0] ADDR_TIMER_A = 16'h2890;
  localparam logic [15:0] ADDR_SCIEB   = 16'h289C;
  localparam logic [15:0] ADDR_SCIRE   = 16'h28A4;
  localparam logic [15:0] ADDR_SCILV0  = 16'h28A8;
  localparam logic [15:0] ADDR_SCILV1  = 16'h28AC;
  localparam logic [15:0] ADDR_SCILV2  = 16'h28B0;
  localparam logic [15:0] ADDR_INTREQ  = 16'h2D00;
  localparam logic [15:0] ADDR_INTCLR  = 16'h2D04;

  typedef struct packed {
    logic [2:0] active;
    logic       fiq;
  } irq_t;

  typedef struct packed {
    logic       tick;
    logic       load;
    logic [7:0] count_val;
    logic [2:0] shift_val;
  } timer_ctl_t;

  typedef logic [LEVEL_ENTRIES-1:0][2:0] level_tbl_t;

  // One interrupt check: latch the level of the lowest live bit when no
  // request is active, otherwise drop the FIQ line. Bits 7 and up share
  // the last level entry.
  function automatic irq_t irq_check(irq_t cur, logic [IRQ_BITS-1:0] live,
                                     level_tbl_t lvl);
    irq_t       r;
    logic [2:0] idx;
    r   = cur;
    idx = 3'(IRQ_TIMER_B);
    for (int b = IRQ_TIMER_B - 1; b >= 0; b--) begin
      if (live[b]) idx = 3'(b);
    end
    if (cur.active == 3'd0 && live != '0) begin
      r.active = lvl[idx];
      r.fiq    = 1'b1;
    end else begin
      r.fiq = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/sound_chip_timers_and_interrupt_ctrl_top.sv =====
// Sound-chip timers and interrupt controller. Each beat is a sample tick,
// a register write or a register read and yields exactly one result beat
// with the read data, the FIQ line and the pending bits after that beat.
// A beat is taken into an input register and processed from there into
// the result register, which drives the output, so one beat is accepted
// every cycle while the output is not stalled; a stalled output holds the
// result while one more beat may wait in the input register.
// Depends on sctic_pkg, sctic_timer and the assertion macro header.
`include "sound_chip_timers_and_interrupt_ctrl_top_macros.svh"

module sound_chip_timers_and_interrupt_ctrl_top #(
  parameter int TIMER_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // reg_addr[15:0], write_data[47:16]
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // read_data[2:0], fiq_line[3], pending_flags[14:4], 0
);

  localparam int NB = sctic_pkg::IRQ_BITS;

  logic        in_valid;
  logic [1:0]  in_type;
  logic [15:0] in_addr;
  logic [31:0] in_data;
  logic        adv;
  logic        do_item;

  logic [NB-1:0]         enable_mask;
  logic [NB-1:0]         pending_bits;
  sctic_pkg::level_tbl_t level_table;
  sctic_pkg::irq_t       irq;

  logic [NB-1:0]         enable_next;
  logic [NB-1:0]         pending_next;
  sctic_pkg::level_tbl_t level_next;
  sctic_pkg::irq_t       irq_next;
  logic [2:0]            rd_next;

  logic [TIMER_COUNT-1:0] wrap;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !in_valid || adv;
  assign do_item  = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_type <= s_tuser;
      in_addr <= s_tdata[15:0];
      in_data <= s_tdata[47:16];
    end
  end

  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_timer
    localparam logic [15:0] TimerAddr = sctic_pkg::ADDR_TIMER_A + 16'(4 * i);
    sctic_pkg::timer_ctl_t ctl;
    assign ctl.tick      = do_item && (in_type == sctic_pkg::REQ_TICK);
    assign ctl.load      = do_item && (in_type == sctic_pkg::REQ_WRITE) &&
                           (in_addr == TimerAddr);
    assign ctl.count_val = in_data[7:0];
    assign ctl.shift_val = in_data[10:8];
    sctic_timer u_timer (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .wrap (wrap[i])
    );
  end

  // Timer wraps are taken in order, each new pending bit running its own
  // check, so a second wrap in the same tick sees the first one's latch.
  always_comb begin
    enable_next  = enable_mask;
    pending_next = pending_bits;
    level_next   = level_table;
    irq_next     = irq;
    rd_next      = 3'd0;
    case (in_type)
      sctic_pkg::REQ_TICK: begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (wrap[i] && !pending_next[sctic_pkg::IRQ_TIMER_A + i]) begin
            pending_next[sctic_pkg::IRQ_TIMER_A + i] = 1'b1;
            irq_next = sctic_pkg::irq_check(irq_next, enable_next & pending_next,
                                            level_next);
          end
        end
      end
      sctic_pkg::REQ_WRITE: begin
        case (in_addr)
          sctic_pkg::ADDR_SCIEB: begin
            enable_next = in_data[NB-1:0];
            irq_next = sctic_pkg::irq_check(irq_next, enable_next & pending_next,
                                            level_next);
          end
          sctic_pkg::ADDR_SCIRE: begin
            pending_next = pending_next & ~in_data[NB-1:0];
            irq_next = sctic_pkg::irq_check(irq_next, enable_next & pending_next,
                                            level_next);
          end
          sctic_pkg::ADDR_SCILV0: begin
            for (int k = 0; k < sctic_pkg::LEVEL_ENTRIES; k++) level_next[k][0] = in_data[k];
          end
          sctic_pkg::ADDR_SCILV1: begin
            for (int k = 0; k < sctic_pkg::LEVEL_ENTRIES; k++) level_next[k][1] = in_data[k];
          end
          sctic_pkg::ADDR_SCILV2: begin
            for (int k = 0; k < sctic_pkg::LEVEL_ENTRIES; k++) level_next[k][2] = in_data[k];
          end
          sctic_pkg::ADDR_INTCLR: begin
            irq_next.active = 3'd0;
            irq_next = sctic_pkg::irq_check(irq_next, enable_next & pending_next,
                                            level_next);
          end
          default: begin
          end
        endcase
      end
      sctic_pkg::REQ_READ: begin
        if (in_addr == sctic_pkg::ADDR_INTREQ) rd_next = irq.active;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask  <= '0;
      pending_bits <= '0;
      level_table  <= '0;
      irq          <= '0;
    end else if (do_item) begin
      enable_mask  <= enable_next;
      pending_bits <= pending_next;
      level_table  <= level_next;
      irq          <= irq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (do_item) begin
      m_tdata <= {1'b0, pending_next, irq_next.fiq, rd_next};
    end
  end

  `SCT_ASSERT_SAME(a_fiq_has_live, irq.fiq, (enable_mask & pending_bits) != '0,
                   "FIQ high with no enabled pending interrupt")
  `SCT_ASSERT_NEXT(a_in_held, in_valid && !adv, in_valid,
                   "input beat lost while output stalled")
  `SCT_ASSERT_NEXT(a_tick_monotone, do_item && in_type == sctic_pkg::REQ_TICK,
                   (pending_bits & $past(pending_bits)) == $past(pending_bits),
                   "sample tick cleared a pending bit")

endmodule

// ===== rtl/core/sctic_timer.sv =====
// One 8-bit timer with a 2^k prescaler and a wrap indication.
// Depends on sctic_pkg for the control struct.
module sctic_timer (
  input  logic                    clk,
  input  logic                    rst,
  input  sctic_pkg::timer_ctl_t   ctl,
  output logic                    wrap
);

  logic [7:0] count;
  logic [7:0] subcount;
  logic [2:0] shift;
  logic [7:0] sub_inc;
  logic       match;

  assign sub_inc = subcount + 8'd1;
  assign match   = (sub_inc == (8'd1 << shift));
  assign wrap    = ctl.tick && match && (count == 8'hFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      subcount <= '0;
      shift    <= '0;
    end else if (ctl.load) begin
      count    <= ctl.count_val;
      shift    <= ctl.shift_val;
      subcount <= '0;
    end else if (ctl.tick) begin
      if (match) begin
        subcount <= '0;
        count    <= count + 8'd1;
      end else begin
        subcount <= sub_inc;
      end
    end
  end

endmodule

// ===== verif/sound_chip_timers_and_interrupt_ctrl_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sound-chip timers and interrupt controller.
// A queue-fed stream driver and a monitor check each result beat against an
// in-bench model of the timers and interrupt logic. Depends on sctic_pkg and the DUT.
module sound_chip_timers_and_interrupt_ctrl_top_tb;

  localparam int TB_TIMERS = 3;
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [15:0] ADDR_TIMER_B = sctic_pkg::ADDR_TIMER_A + 16'h4;
  localparam logic [15:0] ADDR_TIMER_C = sctic_pkg::ADDR_TIMER_A + 16'h8;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [31:0] data;
  } access_t;

  typedef struct packed {
    logic [2:0]  rd;
    logic        fiq;
    logic [10:0] pend;
  } status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // reg_addr[15:0], write_data[47:16]
  logic [1:0]  s_tuser = '0;  // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;       // read_data[2:0], fiq_line[3], pending_flags[14:4], 0

  sound_chip_timers_and_interrupt_ctrl_top #(
    .TIMER_COUNT(TB_TIMERS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state of the controller.
  logic [7:0]            timer_cnt [TB_TIMERS];
  logic [7:0]            timer_sub [TB_TIMERS];
  logic [2:0]            timer_shf [TB_TIMERS];
  logic [10:0]           irq_enable;
  logic [10:0]           irq_pending;
  sctic_pkg::level_tbl_t level_tbl;
  logic [2:0]            req_level;
  logic                  fiq_out;

  access_t pending_accesses[$];
  status_t expected_status_q[$];
  int      accesses_queued = 0;
  int      accesses_taken = 0;
  int      error_count = 0;
  int      send_idle_pct = 13;
  int      recv_idle_pct = 64;
  int      holdoff_asked = 0;
  int      holdoff_done = 0;
  int      holdoff_left = 0;
  logic    in_taken = 1'b0;

  initial begin
    for (int i = 0; i < TB_TIMERS; i++) begin
      timer_cnt[i] = '0;
      timer_sub[i] = '0;
      timer_shf[i] = '0;
    end
    irq_enable  = '0;
    irq_pending = '0;
    level_tbl   = '0;
    req_level   = '0;
    fiq_out     = 1'b0;
  end

  // Latch the level of the lowest live interrupt when no request is active;
  // any other check drops the FIQ line.
  function automatic void irq_recheck();
    logic [10:0] live;
    int          idx;
    live = irq_enable & irq_pending;
    if (req_level == 3'd0 && live != '0) begin
      idx = sctic_pkg::IRQ_BITS - 1;
      for (int b = sctic_pkg::IRQ_BITS - 1; b >= 0; b--) begin
        if (live[b]) idx = b;
      end
      if (idx > sctic_pkg::IRQ_TIMER_B) idx = sctic_pkg::IRQ_TIMER_B;
      req_level = level_tbl[idx];
      fiq_out = 1'b1;
    end else begin
      fiq_out = 1'b0;
    end
  endfunction

  function automatic void load_timer(int t, logic [31:0] data);
    timer_cnt[t] = data[7:0];
    timer_shf[t] = data[10:8];
    timer_sub[t] = '0;
  endfunction

  function automatic status_t predict_status(access_t a);
    status_t s;
    s.rd = '0;
    if (a.kind == sctic_pkg::REQ_TICK) begin
      for (int i = 0; i < TB_TIMERS; i++) begin
        timer_sub[i] = timer_sub[i] + 8'd1;
        if (timer_sub[i] == 8'(1 << timer_shf[i])) begin
          timer_sub[i] = '0;
          timer_cnt[i] = timer_cnt[i] + 8'd1;
          // A wrap onto a bit that is already pending changes nothing.
          if (timer_cnt[i] == 8'd0 && !irq_pending[sctic_pkg::IRQ_TIMER_A + i]) begin
            irq_pending[sctic_pkg::IRQ_TIMER_A + i] = 1'b1;
            irq_recheck();
          end
        end
      end
    end else if (a.kind == sctic_pkg::REQ_WRITE) begin
      case (a.addr)
        sctic_pkg::ADDR_TIMER_A: load_timer(0, a.data);
        ADDR_TIMER_B: if (TB_TIMERS > 1) load_timer(1, a.data);
        ADDR_TIMER_C: if (TB_TIMERS > 2) load_timer(2, a.data);
        sctic_pkg::ADDR_SCIEB: begin
          irq_enable = a.data[10:0];
          irq_recheck();
        end
        sctic_pkg::ADDR_SCIRE: begin
          irq_pending = irq_pending & ~a.data[10:0];
          irq_recheck();
        end
        sctic_pkg::ADDR_SCILV0: begin
          for (int k = 0; k < sctic_pkg::LEVEL_ENTRIES; k++) level_tbl[k][0] = a.data[k];
        end
        sctic_pkg::ADDR_SCILV1: begin
          for (int k = 0; k < sctic_pkg::LEVEL_ENTRIES; k++) level_tbl[k][1] = a.data[k];
        end
        sctic_pkg::ADDR_SCILV2: begin
          for (int k = 0; k < sctic_pkg::LEVEL_ENTRIES; k++) level_tbl[k][2] = a.data[k];
        end
        sctic_pkg::ADDR_INTCLR: begin
          req_level = '0;
          irq_recheck();
        end
        default: ;
      endcase
    end else if (a.kind == sctic_pkg::REQ_READ && a.addr == sctic_pkg::ADDR_INTREQ) begin
      s.rd = req_level;
    end
    s.fiq  = fiq_out;
    s.pend = irq_pending;
    return s;
  endfunction

  function automatic access_t random_access();
    access_t a;
    int      pick;
    a.data = $urandom();
    pick = $urandom_range(99);
    if (pick < 45) a.kind = sctic_pkg::REQ_TICK;
    else if (pick < 88) a.kind = sctic_pkg::REQ_WRITE;
    else if (pick < 97) a.kind = sctic_pkg::REQ_READ;
    else a.kind = REQ_NONE;
    case ($urandom_range(11))
      0, 1: a.addr = sctic_pkg::ADDR_TIMER_A;
      2: a.addr = ADDR_TIMER_B;
      3: a.addr = ADDR_TIMER_C;
      4: a.addr = sctic_pkg::ADDR_SCIEB;
      5: a.addr = sctic_pkg::ADDR_SCIRE;
      6: a.addr = sctic_pkg::ADDR_SCILV0;
      7: a.addr = sctic_pkg::ADDR_SCILV1;
      8: a.addr = sctic_pkg::ADDR_SCILV2;
      9: a.addr = sctic_pkg::ADDR_INTCLR;
      10: a.addr = sctic_pkg::ADDR_INTREQ;
      default: a.addr = 16'($urandom());
    endcase
    if (a.kind == sctic_pkg::REQ_READ && $urandom_range(3) != 0) begin
      a.addr = sctic_pkg::ADDR_INTREQ;
    end
    // Most timer loads sit just below the wrap with a short prescale so that
    // the ticks actually raise timer interrupts.
    if ((a.addr == sctic_pkg::ADDR_TIMER_A || a.addr == ADDR_TIMER_B ||
         a.addr == ADDR_TIMER_C) && $urandom_range(4) != 0) begin
      a.data[7:0]  = 8'(255 - $urandom_range(12));
      a.data[10:8] = 3'($urandom_range(2));
    end
    if (a.addr == sctic_pkg::ADDR_SCIEB && $urandom_range(1) == 1) a.data[8:6] = 3'b111;
    return a;
  endfunction

  task automatic queue_access(logic [1:0] kind, logic [15:0] addr, logic [31:0] data);
    access_t a;
    a.kind = kind;
    a.addr = addr;
    a.data = data;
    pending_accesses.push_back(a);
    accesses_queued++;
  endtask

  task automatic queue_random(int count);
    for (int n = 0; n < count; n++) begin
      pending_accesses.push_back(random_access());
      accesses_queued++;
    end
  endtask

  // Returns on a rising edge once every queued beat has been taken and
  // every expected result has come back.
  task automatic drain();
    do @(negedge clk);
    while (accesses_taken != accesses_queued || expected_status_q.size() != 0);
    @(posedge clk);
  endtask

  task automatic report(string field, int unsigned exp_val, int unsigned act_val);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
    error_count++;
  endtask

  // Input driver: a new beat is offered only after the previous one was taken.
  always @(negedge clk) begin
    access_t a;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        a = pending_accesses.pop_front();
        s_tdata  <= {a.data, a.addr};
        s_tuser  <= a.kind;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output ready, with a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (holdoff_left != 0) begin
      m_tready     <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_done != holdoff_asked) begin
      holdoff_done <= holdoff_asked;
      holdoff_left <= HOLDOFF_CYCLES;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on each accepted input beat, check each output beat.
  always @(posedge clk) begin
    access_t a;
    status_t exp_s;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        a.kind = s_tuser;
        a.addr = s_tdata[15:0];
        a.data = s_tdata[47:16];
        expected_status_q.push_back(predict_status(a));
        accesses_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_status_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %0h", $time, m_tdata);
          error_count++;
        end else begin
          exp_s = expected_status_q.pop_front();
          if (m_tdata[2:0] !== exp_s.rd) report("read_data", exp_s.rd, m_tdata[2:0]);
          if (m_tdata[3] !== exp_s.fiq) report("fiq_line", exp_s.fiq, m_tdata[3]);
          if (m_tdata[14:4] !== exp_s.pend) report("pending_flags", exp_s.pend, m_tdata[14:4]);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sequence: timer wraps, level lookup, clears and odd addresses.
    queue_access(sctic_pkg::REQ_READ, sctic_pkg::ADDR_INTREQ, 32'h0);
    queue_access(sctic_pkg::REQ_WRITE, sctic_pkg::ADDR_SCIEB, 32'hFFFF_FFFF);
    queue_access(sctic_pkg::REQ_WRITE, sctic_pkg::ADDR_TIMER_A, 32'h0000_00FF);
    // All levels are still zero, so this wrap latches level zero with FIQ high.
    queue_access(sctic_pkg::REQ_TICK, 16'h0000, 32'h0);
    queue_access(sctic_pkg::REQ_WRITE, sctic_pkg::ADDR_SCILV0, 32'h0000_00FF);
    queue_access(sctic_pkg::REQ_WRITE, sctic_pkg::ADDR_SCILV1, 32'hFFFF_FF00);
    queue_access(sctic_pkg::REQ_WRITE, sctic_pkg::ADDR_SCILV2, 32'h0000_00A5);
    queue_access(sctic_pkg::REQ_WRITE, sctic_pkg::ADDR_SCIRE, 32'hFFFF_FFFF);
    queue_access(sctic_pkg::REQ_WRITE, sctic_pkg::ADDR_INTCLR, 32'h0);
    // Timer C raises bit 8, which shares the level of bit 7.
    queue_access(sctic_pkg::REQ_WRITE, ADDR_TIMER_C, 32'h0000_F8FF);
    queue_access(sctic_pkg::REQ_TICK, 16'hFFFF, 32'hFFFF_FFFF);
    queue_access(sctic_pkg::REQ_TICK, 16'h0000, 32'h0);
    queue_access(sctic_pkg::REQ_READ, sctic_pkg::ADDR_INTREQ, 32'hFFFF_FFFF);
    queue_access(sctic_pkg::REQ_WRITE, ADDR_TIMER_B, 32'h0000_07FF);
    queue_access(sctic_pkg::REQ_WRITE, 16'h1234, 32'hFFFF_FFFF);
    queue_access(sctic_pkg::REQ_READ, 16'hFFFF, 32'h0);
    queue_access(REQ_NONE, sctic_pkg::ADDR_INTREQ, 32'hFFFF_FFFF);
    queue_access(sctic_pkg::REQ_WRITE, sctic_pkg::ADDR_TIMER_A, 32'h0000_00FF);
    // A wrap while a request is active sets its pending bit but only drops FIQ.
    queue_access(sctic_pkg::REQ_TICK, 16'h0000, 32'h0);
    queue_access(sctic_pkg::REQ_WRITE, sctic_pkg::ADDR_TIMER_A, 32'hFFFF_F8FF);
    // Timer A wraps again onto a bit that is already pending.
    queue_access(sctic_pkg::REQ_TICK, 16'h0000, 32'h0);
    queue_access(sctic_pkg::REQ_WRITE, sctic_pkg::ADDR_INTCLR, 32'hFFFF_FFFF);
    queue_access(sctic_pkg::REQ_READ, sctic_pkg::ADDR_INTREQ, 32'h0);
    queue_access(sctic_pkg::REQ_WRITE, sctic_pkg::ADDR_SCIEB, 32'h0);
    queue_access(sctic_pkg::REQ_READ, sctic_pkg::ADDR_INTREQ, 32'h0);
    queue_random(300);
    // The sender waits here until every result is back.
    drain();

    send_idle_pct = 64;
    recv_idle_pct = 13;
    queue_random(300);
    drain();

    // No idling, and a long output stall that backs up the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holdoff_asked = holdoff_asked + 1;
    queue_random(300);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
